// ----- design/rud_pkg.sv -----
`default_nettype none

package rud_pkg;

    // Default operand width of the divider.
    localparam int DIV_WIDTH = 32;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/rud_datapath.sv -----
`default_nettype none

module rud_datapath
    import rud_pkg::*;
#(
    parameter int WIDTH = DIV_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [WIDTH-1:0] i_dividend,
    input  wire logic [WIDTH-1:0] i_divisor,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_stat              o_stat,
    output logic      [WIDTH-1:0] o_quotient
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_num;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_out;
    logic             r_zero;
    logic [CW-1:0]    r_count;

    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_quo;
    logic [WIDTH-1:0] w_final;

    // One restoring step: shift the next dividend bit in, subtract when it fits.
    // The extra top bit keeps the carry out of the shift.
    always_comb begin
        w_shift = {r_rem, r_num[WIDTH-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
        n_quo   = {r_quo[WIDTH-2:0], w_ge};
    end

    // The result is the quotient of the final step, or the stored one when it waited.
    assign w_final = i_cmd.step ? n_quo : r_quo;

    // Operand, remainder and quotient registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quo  <= '0;
            r_zero <= (i_divisor == '0);
        end else if (i_cmd.step) begin
            r_num <= {r_num[WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Step counter, counting down to the least significant bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= CW'(WIDTH - 1);
        end else if (i_cmd.step) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Output register; a zero divisor gives a zero quotient.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_zero ? '0 : w_final;
        end
    end

    assign o_stat.last = (r_count == '0);
    assign o_quotient  = r_out;

endmodule

`default_nettype wire

// ----- design/rud_ctrl.sv -----
`default_nettype none

module rud_ctrl
    import rud_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire logic     i_stall,
    input  wire t_dp_stat i_stat,
    output logic          o_stall,
    output logic          o_valid,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_done;

    // The output register can take a result when empty or being read this cycle.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_done     = ((r_state == S_RUN) && i_stat.last) || (r_state == S_HOLD);

    // Commands to the datapath.
    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.step     = (r_state == S_RUN);
        o_cmd.out_load = w_done && w_out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_stat.last) begin
                    n_state = w_out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output item valid flag.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- design/restoring_unsigned_divider.sv -----
// Unsigned restoring divider: quotient = floor(dividend / divisor).
// Input channel: i_valid, o_stall, i_dividend, i_divisor. An item is taken
// at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid, i_stall, o_quotient. An item leaves at a clock
// edge where o_valid is high and i_stall is low.
// A zero divisor gives a quotient of zero.
// The quotient is computed one bit per cycle through a single
// subtract-and-compare unit. The block takes the next item in the cycle
// after the result has moved into the output register.
// The output register lets a new item start while a result still waits.
// If the output register still holds an unread quotient when a division ends,
// the new quotient is held inside and o_stall stays high until the receiver
// takes the waiting one.
// Reset (synchronous, active low) returns the controller to idle and empties
// the output register; an item in flight is dropped.
`default_nettype none

module restoring_unsigned_divider
    import rud_pkg::*;
#(
    parameter int WIDTH = DIV_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [WIDTH-1:0] i_dividend,
    input  wire logic [WIDTH-1:0] i_divisor,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [WIDTH-1:0] o_quotient
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencing of load, steps and result hand-off.
    rud_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    // Shift-and-subtract datapath with the output register.
    rud_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_quotient (o_quotient)
    );

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_valid || !i_stall))
        else $error("output register loaded while holding an unread item");

    // Taking an item makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after taking an item");

    // The block becomes free again only after handing a result over.
    a_free_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(o_stall)) |-> $past(w_cmd.out_load))
        else $error("block freed without delivering a result");

    // Loading and stepping never happen together.
    a_load_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load && w_cmd.step))
        else $error("load and step issued together");

endmodule

`default_nettype wire

// ----- tb/tb_restoring_unsigned_divider.sv -----
`default_nettype none

module tb_restoring_unsigned_divider
    import rud_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH       = DIV_WIDTH;
    localparam int RANDOM_ITEMS = 1830;
    localparam logic [WIDTH-1:0] ALL_ONES = '1;
    localparam logic [WIDTH-1:0] TOP_BIT  = {1'b1, {(WIDTH-1){1'b0}}};

    // One division request, with a flag that makes the sender wait until
    // every outstanding quotient has come back before offering it.
    typedef struct {
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
        bit               drain;
    } t_div_item;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic [WIDTH-1:0] i_dividend = '0;
    logic [WIDTH-1:0] i_divisor  = '0;
    logic             i_stall    = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [WIDTH-1:0] o_quotient;

    t_div_item        pending_q[$];
    logic [WIDTH-1:0] quotient_q[$];
    int               mismatch_count = 0;
    int               quotients_seen = 0;

    restoring_unsigned_divider #(
        .WIDTH(WIDTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_quotient (o_quotient)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Long division with a partial remainder one bit wider than the operands,
    // so the bit shifted out of the top is never lost.
    function automatic logic [WIDTH-1:0] calc_quotient(input logic [WIDTH-1:0] num,
                                                       input logic [WIDTH-1:0] den);
        logic [WIDTH:0]   part;
        logic [WIDTH-1:0] quo;
        part = '0;
        quo  = '0;
        if (den == '0) begin
            return '0;
        end
        for (int k = WIDTH - 1; k >= 0; k--) begin
            part = {part[WIDTH-1:0], num[k]};
            quo  = quo << 1;
            if (part >= {1'b0, den}) begin
                part   = part - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Queues one request for the sender.
    task automatic add_item(input logic [WIDTH-1:0] num, input logic [WIDTH-1:0] den,
                            input bit drain);
        t_div_item item;
        item.dividend = num;
        item.divisor  = den;
        item.drain    = drain;
        pending_q.push_back(item);
    endtask

    // Random operands, drawn from several shapes so that small quotients, huge
    // quotients, zero divisors and the top-bit carry case all turn up often.
    task automatic add_random_item(input bit drain);
        logic [WIDTH-1:0] num;
        logic [WIDTH-1:0] den;
        logic [WIDTH-1:0] mult;
        num = $urandom;
        den = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
            end
            3: begin
                den = $urandom_range(1, 255);
            end
            4: begin
                den = den >> $urandom_range(0, WIDTH - 1);
            end
            5: begin
                num = num >> $urandom_range(0, WIDTH - 1);
            end
            6: begin
                if ($urandom_range(0, 1) == 0) begin
                    den = num - $urandom_range(0, 3);
                end else begin
                    den = num + $urandom_range(0, 3);
                end
            end
            7: begin
                num = num | TOP_BIT;
                den = den | TOP_BIT;
            end
            8: begin
                case ($urandom_range(0, 2))
                    0: den = '0;
                    1: den = 1;
                    default: den = TOP_BIT >> $urandom_range(0, WIDTH - 1);
                endcase
            end
            default: begin
                den  = den >> $urandom_range(WIDTH / 2, WIDTH - 1);
                mult = $urandom >> $urandom_range(WIDTH / 2, WIDTH - 1);
                num  = den * mult + $urandom_range(0, 2);
            end
        endcase
        add_item(num, den, drain);
    endtask

    // Sender: offers items from the pending queue in bursts with random gaps,
    // and records the expected quotient of each item that is taken.
    int burst_left = 4;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_div_item item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                quotient_q.push_back(calc_quotient(i_dividend, i_divisor));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_q[0].drain && quotient_q.size() != 0) begin
                    i_valid <= 1'b0;
                end else begin
                    item = pending_q.pop_front();
                    i_valid    <= 1'b1;
                    i_dividend <= item.dividend;
                    i_divisor  <= item.divisor;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 15) == 0) begin
                            // A long stretch offered back to back.
                            burst_left = 60;
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = ($urandom_range(0, 9) < 3) ? 0
                                                                    : $urandom_range(1, 45);
                        end
                    end
                end
            end
        end
    end

    // Receiver stall: the pattern is redrawn from four modes as the run goes on, and
    // twice the receiver holds off for a long stretch so that the divider backs up.
    int stall_mode  = 0;
    int mode_cycles = 0;
    int hold_left   = 0;
    int holds_done  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            mode_cycles = mode_cycles + 1;
            if (mode_cycles >= 128) begin
                mode_cycles = 0;
                stall_mode  = $urandom_range(0, 3);
            end
            if ((holds_done == 0 && quotients_seen >= 200) ||
                (holds_done == 1 && quotients_seen >= 1200)) begin
                holds_done = holds_done + 1;
                hold_left  = 500;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= mode_cycles[0];
                endcase
            end
        end
    end

    // Result check: every quotient taken is matched against the oldest
    // expectation.
    always @(posedge i_clk) begin
        logic [WIDTH-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            quotients_seen <= quotients_seen + 1;
            if (quotient_q.size() == 0) begin
                $error("quotient: expected none, actual %h", o_quotient);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = quotient_q.pop_front();
                if (o_quotient !== want) begin
                    $error("quotient: expected %h, actual %h", want, o_quotient);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        // Directed: operand extremes, zero divisor, dividend below divisor,
        // and operands with the top bit set where the remainder carries.
        add_item('0, '0, 1'b0);
        add_item(ALL_ONES, '0, 1'b0);
        add_item(1, '0, 1'b0);
        add_item('0, ALL_ONES, 1'b0);
        add_item(ALL_ONES, ALL_ONES, 1'b0);
        add_item(ALL_ONES - 1, ALL_ONES, 1'b0);
        add_item(ALL_ONES, 1, 1'b0);
        add_item(ALL_ONES, 2, 1'b0);
        add_item(1, 1, 1'b0);
        add_item(5, 7, 1'b0);
        add_item(TOP_BIT, 1, 1'b0);
        add_item(TOP_BIT, TOP_BIT, 1'b0);
        add_item(ALL_ONES, TOP_BIT, 1'b0);
        add_item(ALL_ONES, TOP_BIT + 1, 1'b0);
        add_item(TOP_BIT - 1, ALL_ONES, 1'b0);
        add_item(TOP_BIT - 1, TOP_BIT, 1'b0);
        add_item(ALL_ONES, 3, 1'b0);
        add_item(32'h1234_5678, 32'h0000_0010, 1'b0);
        add_item(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        add_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        add_item(32'hFFFF_0000, 32'h0000_FFFF, 1'b0);
        add_item(32'hDEAD_BEEF, 32'h0001_0000, 1'b0);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            add_random_item(n % 450 == 0);
        end

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (quotient_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * WIDTH + 8) @(posedge i_clk);

        if (mismatch_count == 0 && quotient_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
